FILE: rtl/sdaf_pkg.sv
`default_nettype none

package sdaf_pkg;

	localparam int MAG_W    = 32;
	localparam int THR_W    = 34;
	localparam int DIGIT_W  = 4;
	localparam int POS_W    = 4;
	localparam int NUM_CONV = 10;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// classification of one converted value, handed from front to back
	typedef struct packed {
		logic             neg;
		logic             zero;
		logic             extra;
		logic [POS_W-1:0] lead;
	} fmt_cls_t;

	function automatic logic [THR_W-1:0] pow10(input logic [POS_W-1:0] pos);
		logic [THR_W-1:0] p;
		case (pos)
			4'd0:    p = 34'd1;
			4'd1:    p = 34'd10;
			4'd2:    p = 34'd100;
			4'd3:    p = 34'd1000;
			4'd4:    p = 34'd10000;
			4'd5:    p = 34'd100000;
			4'd6:    p = 34'd1000000;
			4'd7:    p = 34'd10000000;
			4'd8:    p = 34'd100000000;
			4'd9:    p = 34'd1000000000;
			default: p = 34'd1;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/signed_decimal_ascii_formatter.sv
`default_nettype none

// Formats a signed 32-bit value as right-justified decimal ASCII, DIGIT_POSITIONS
// wide, one character per cycle (while a converted value is queued) on character/last,
// marked by strobe. Leading zeros are spaces, a minus sign sits just before the first
// digit (or is prepended when the digits fill the field), and zero gives DIGIT_POSITIONS
// spaces then '0'. A value is taken when start is high and busy is low; the front
// converts it one decimal digit per cycle and takes no new value until the result is
// handed into a two-entry queue, held off while that queue is full. The back emits
// DIGIT_POSITIONS or DIGIT_POSITIONS+1 characters per value, back to back across values.
// The receiver cannot stall: every strobed character must be taken in that cycle.
module signed_decimal_ascii_formatter #(
	parameter int DIGIT_POSITIONS = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] value,
	output logic                    strobe,
	output logic [7:0]              character,
	output logic                    last
);

	sdaf_pkg::fmt_cls_t                                f_cls;
	sdaf_pkg::fmt_cls_t                                q_cls;
	logic [DIGIT_POSITIONS-1:0][sdaf_pkg::DIGIT_W-1:0] f_digits;
	logic [DIGIT_POSITIONS-1:0][sdaf_pkg::DIGIT_W-1:0] q_digits;
	logic                                              push;
	logic                                              pop;
	logic                                              full;
	logic                                              empty;

	sdaf_front #(
		.DIGIT_POSITIONS(DIGIT_POSITIONS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.full   (full),
		.busy   (busy),
		.push   (push),
		.cls    (f_cls),
		.digits (f_digits)
	);

	sdaf_queue #(
		.DIGIT_POSITIONS(DIGIT_POSITIONS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.cls_in     (f_cls),
		.digits_in  (f_digits),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.cls_out    (q_cls),
		.digits_out (q_digits)
	);

	sdaf_back #(
		.DIGIT_POSITIONS(DIGIT_POSITIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.cls       (q_cls),
		.digits    (q_digits),
		.pop       (pop),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

FILE: rtl/sdaf_front.sv
`default_nettype none

module sdaf_front #(
	parameter int DIGIT_POSITIONS = 10
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               start,
	input  wire logic signed [sdaf_pkg::MAG_W-1:0]                  value,
	input  wire logic                                               full,
	output logic                                                    busy,
	output logic                                                    push,
	output sdaf_pkg::fmt_cls_t                                      cls,
	output logic [DIGIT_POSITIONS-1:0][sdaf_pkg::DIGIT_W-1:0]       digits
);

	localparam logic [sdaf_pkg::POS_W-1:0] LAST_POS  = sdaf_pkg::POS_W'(DIGIT_POSITIONS - 1);
	localparam logic [sdaf_pkg::POS_W-1:0] FIRST_CNT = sdaf_pkg::POS_W'(sdaf_pkg::NUM_CONV - 1);

	logic                                              active_q;
	logic                                              done_q;
	logic [sdaf_pkg::POS_W-1:0]                        cnt_q;
	logic [sdaf_pkg::MAG_W-1:0]                        rem_q;
	logic                                              neg_q;
	logic [DIGIT_POSITIONS-1:0][sdaf_pkg::DIGIT_W-1:0] dig_q;
	logic [DIGIT_POSITIONS-1:0][sdaf_pkg::DIGIT_W-1:0] dig_n;

	logic                          accept;
	logic [sdaf_pkg::MAG_W-1:0]    raw;
	logic [sdaf_pkg::MAG_W-1:0]    mag;
	logic [sdaf_pkg::THR_W-1:0]    thr [1:9];
	logic [sdaf_pkg::DIGIT_W-1:0]  d;
	logic [sdaf_pkg::MAG_W-1:0]    sub;
	logic                          zero;
	logic [sdaf_pkg::POS_W-1:0]    lead;

	assign push   = done_q && !full;
	assign busy   = active_q && !push;
	assign accept = start && !busy;

	assign raw = value;
	assign mag = raw[sdaf_pkg::MAG_W-1] ? (~raw + 32'd1) : raw;

	always_comb begin
		for (int k = 1; k <= 9; k++) begin
			thr[k] = sdaf_pkg::THR_W'(k) * sdaf_pkg::pow10(cnt_q);
		end
	end

	// digit = number of multiples of the current power of ten that fit
	always_comb begin
		d   = '0;
		sub = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({2'b00, rem_q} >= thr[k]) begin
				d   = sdaf_pkg::DIGIT_W'(k);
				sub = thr[k][sdaf_pkg::MAG_W-1:0];
			end
		end
	end

	// digits arrive MSB first; high ones beyond the shown width fall off the top
	always_comb begin
		for (int j = 0; j < DIGIT_POSITIONS; j++) begin
			if (j == 0) begin
				dig_n[j] = d;
			end else begin
				dig_n[j] = dig_q[j-1];
			end
		end
	end

	always_comb begin
		zero = 1'b1;
		lead = '0;
		for (int j = 0; j < DIGIT_POSITIONS; j++) begin
			if (dig_q[j] != '0) begin
				zero = 1'b0;
				lead = sdaf_pkg::POS_W'(j);
			end
		end
	end

	assign cls.neg   = neg_q;
	assign cls.zero  = zero;
	assign cls.extra = neg_q && !zero && (lead == LAST_POS);
	assign cls.lead  = lead;
	assign digits    = dig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			done_q   <= 1'b0;
			cnt_q    <= FIRST_CNT;
		end else if (push) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else if (active_q && !done_q) begin
			if (cnt_q == '0) begin
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= mag;
			neg_q <= raw[sdaf_pkg::MAG_W-1];
		end else if (active_q && !done_q) begin
			rem_q <= rem_q - sub;
			dig_q <= dig_n;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> active_q && !done_q && cnt_q == FIRST_CNT)
		else $error("conversion did not start after accept");

	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> active_q && cnt_q == '0)
		else $error("conversion finished early");

endmodule

`default_nettype wire

FILE: rtl/sdaf_queue.sv
`default_nettype none

module sdaf_queue #(
	parameter int DIGIT_POSITIONS = 10
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               push,
	input  wire sdaf_pkg::fmt_cls_t                                 cls_in,
	input  wire logic [DIGIT_POSITIONS-1:0][sdaf_pkg::DIGIT_W-1:0]  digits_in,
	input  wire logic                                               pop,
	output logic                                                    full,
	output logic                                                    empty,
	output sdaf_pkg::fmt_cls_t                                      cls_out,
	output logic [DIGIT_POSITIONS-1:0][sdaf_pkg::DIGIT_W-1:0]       digits_out
);

	sdaf_pkg::fmt_cls_t                                cls_mem [2];
	logic [DIGIT_POSITIONS-1:0][sdaf_pkg::DIGIT_W-1:0] dig_mem [2];

	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign empty      = (cnt_q == 2'd0);
	assign cls_out    = cls_mem[rd_q];
	assign digits_out = dig_mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cls_mem[wr_q] <= cls_in;
			dig_mem[wr_q] <= digits_in;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/sdaf_back.sv
`default_nettype none

module sdaf_back #(
	parameter int DIGIT_POSITIONS = 10
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               empty,
	input  wire sdaf_pkg::fmt_cls_t                                 cls,
	input  wire logic [DIGIT_POSITIONS-1:0][sdaf_pkg::DIGIT_W-1:0]  digits,
	output logic                                                    pop,
	output logic                                                    strobe,
	output logic [7:0]                                              character,
	output logic                                                    last
);

	localparam int IDX_W = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;
	localparam logic [sdaf_pkg::POS_W-1:0] LAST_POS = sdaf_pkg::POS_W'(DIGIT_POSITIONS - 1);
	localparam logic [sdaf_pkg::POS_W-1:0] NUM_POS  = sdaf_pkg::POS_W'(DIGIT_POSITIONS);

	logic [sdaf_pkg::POS_W-1:0] k_q;
	logic                       strobe_q;
	logic [7:0]                 character_q;
	logic                       last_q;

	logic [sdaf_pkg::POS_W-1:0] last_k;
	logic [sdaf_pkg::POS_W-1:0] pos;
	logic                       is_last;
	logic [7:0]                 ch;

	// an extra character appears for zero (the '0' trailer) or a full-width negative (a leading minus)
	assign last_k  = (cls.zero || cls.extra) ? NUM_POS : LAST_POS;
	assign is_last = (k_q == last_k);
	assign pop     = !empty && is_last;
	assign pos     = cls.extra ? (NUM_POS - k_q) : (LAST_POS - k_q);

	always_comb begin
		if (cls.extra && k_q == '0) begin
			ch = sdaf_pkg::CH_MINUS;
		end else if (cls.zero) begin
			ch = (k_q == NUM_POS) ? sdaf_pkg::CH_ZERO : sdaf_pkg::CH_SPACE;
		end else if (pos > cls.lead) begin
			ch = (cls.neg && pos == cls.lead + 4'd1) ? sdaf_pkg::CH_MINUS : sdaf_pkg::CH_SPACE;
		end else begin
			ch = sdaf_pkg::CH_ZERO + {4'b0000, digits[pos[IDX_W-1:0]]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= !empty;
			if (!empty) begin
				k_q <= is_last ? '0 : (k_q + 4'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!empty) begin
			character_q <= ch;
			last_q      <= is_last;
		end
	end

	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q;

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> strobe_q && last_q)
		else $error("transaction end not flagged");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && character_q == sdaf_pkg::CH_MINUS |-> !last_q)
		else $error("minus sign as final character");

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int POSITIONS = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_char_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] value;
	logic               strobe;
	logic [7:0]         character;
	logic               last;

	text_char_t expected_text[$];
	int         mismatch_count;
	int         max_gap;

	signed_decimal_ascii_formatter #(
		.DIGIT_POSITIONS(POSITIONS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.strobe   (strobe),
		.character(character),
		.last     (last)
	);

	always #10 clk = ~clk;

	// Right-justified text for one value, queued in output order.
	function automatic void predict_text(input logic signed [31:0] v);
		logic        neg;
		logic [31:0] mag32;
		logic [63:0] mag;
		logic [63:0] scale;
		logic [63:0] modulus;
		logic [3:0]  d;
		logic [7:0]  text [12];
		int          n;
		int          i;
		bit          started;
		modulus = 64'd1;
		for (i = 0; i < POSITIONS; i++)
			modulus = modulus * 10;
		neg = v[31];
		// unsigned magnitude keeps the most negative value intact
		mag32 = neg ? (32'd0 - $unsigned(v)) : $unsigned(v);
		mag = {32'd0, mag32} % modulus;
		scale = modulus / 10;
		n = 0;
		started = 1'b0;
		for (i = POSITIONS - 1; i >= 0; i--) begin
			d = 4'((mag / scale) % 10);
			if (d != 0 || started) begin
				if (!started && neg) begin
					// minus replaces the preceding space, or leads when there is none
					if (n == 0) begin
						text[n] = sdaf_pkg::CH_MINUS;
						n++;
					end else begin
						text[n-1] = sdaf_pkg::CH_MINUS;
					end
				end
				text[n] = sdaf_pkg::CH_ZERO + {4'b0000, d};
				n++;
				started = 1'b1;
			end else begin
				text[n] = sdaf_pkg::CH_SPACE;
				n++;
			end
			scale = scale / 10;
		end
		if (!started) begin
			text[n] = sdaf_pkg::CH_ZERO;
			n++;
		end
		for (i = 0; i < n; i++)
			expected_text.push_back('{ch: text[i], fin: (i == n - 1)});
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_value(input logic signed [31:0] v);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			value <= $urandom;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
		predict_text(v);
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_value(32'sd0);
		send_value(32'sd1);
		send_value(-32'sd1);
		send_value(32'sd9);
		send_value(-32'sd9);
		send_value(32'sd10);
		send_value(-32'sd10);
		send_value(32'sd100);
		send_value(-32'sd100);
		send_value(32'sd999999999);
		send_value(-32'sd999999999);
		send_value(32'sd1000000000);
		send_value(-32'sd1000000000);
		send_value(32'sd1234567890);
		send_value(-32'sd1234567890);
		send_value(32'sd1000000007);
		send_value(-32'sd2000000000);
		send_value(32'sd2147483647);
		send_value(32'h8000_0000);
		send_value(-32'sd2147483647);
		send_value(32'sd0);
		send_value(-32'sd5);
	endtask

	// Values spread evenly over digit counts, both signs.
	task automatic test_digit_counts(input int count);
		int          n;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mag;
		bit          neg;
		repeat (count) begin
			n = $urandom_range(1, 10);
			neg = 1'($urandom_range(0, 1));
			lo = 64'd1;
			repeat (n - 1) lo = lo * 10;
			hi = lo * 10 - 1;
			if (n == 1)
				lo = 64'd0;
			if (hi > 64'd2147483647)
				hi = neg ? 64'd2147483648 : 64'd2147483647;
			mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
			send_value(neg ? (32'd0 - mag[31:0]) : mag[31:0]);
		end
	endtask

	task automatic test_raw_values(input int count);
		repeat (count)
			send_value($urandom);
	endtask

	// start held high throughout, values back to back
	task automatic test_back_to_back(input int count);
		int saved_gap;
		saved_gap = max_gap;
		max_gap = 0;
		test_digit_counts(count / 2);
		test_raw_values(count - count / 2);
		max_gap = saved_gap;
	endtask

	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && strobe) begin
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual char 0x%02h last %0b",
					$time, character, last);
				mismatch_count++;
			end else begin
				exp_c = expected_text.pop_front();
				if (character !== exp_c.ch) begin
					$display("%0t: character mismatch, expected 0x%02h, actual 0x%02h",
						$time, exp_c.ch, character);
					mismatch_count++;
				end
				if (last !== exp_c.fin) begin
					$display("%0t: last mismatch, expected %0b, actual %0b",
						$time, exp_c.fin, last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		mismatch_count = 0;
		max_gap = 9;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_digit_counts(200);
		test_back_to_back(60);
		test_raw_values(160);
		test_back_to_back(40);

		start <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/sdaf_pkg.sv
rtl/sdaf_front.sv
rtl/sdaf_queue.sv
rtl/sdaf_back.sv
rtl/signed_decimal_ascii_formatter.sv
verif/tb.sv
